@@ rtl/mhpq_pkg.sv @@
// Shared types, widths and codes for the min-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 32;
  localparam int ENTRY_W      = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic signed [KEY_W-1:0] EMPTY_TOP = -32'sd1;

  typedef struct packed {
    logic                    opcode;
    logic signed [KEY_W-1:0] key_value;
  } mhpq_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] removed_value;
    logic signed [KEY_W-1:0] top_value;
    logic [ENTRY_W-1:0]      entry_count;
    logic                    heap_empty;
  } mhpq_out_t;

endpackage

@@ rtl/min_heap_priority_queue.sv @@
// Top level: binary min-heap of signed keys, sifted by a small sequencer.
// Insert: the new key climbs k levels toward the root (k <= log2 CAPACITY).
// Remove: k levels descended; the descent is skipped when the remove empties the heap.
// A full insert or empty remove reports without touching the heap; busy is high until the result is strobed.
// Results are strobed for one cycle; the receiver cannot stall, so none is ever held.
// Reset clears the count, sequencer and result strobe only; heap memory is not cleared.
`timescale 1ns / 1ps

module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mhpq_in_t  in_data,
  output logic      out_strobe,
  output mhpq_out_t out_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CH_W  = IDX_W + 2;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_UP      = 8'b0000_0010,
    S_UP_CMP  = 8'b0000_0100,
    S_DN_LAST = 8'b0000_1000,
    S_DN      = 8'b0001_0000,
    S_DN_CMPL = 8'b0010_0000,
    S_DN_CMPR = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic signed [KEY_W-1:0] cur_r, cur_nxt;
  logic signed [KEY_W-1:0] best_r, best_nxt;
  logic                    take_l_r, take_l_nxt;
  logic [1:0]              status_r, status_nxt;
  logic signed [KEY_W-1:0] removed_r, removed_nxt;
  logic signed [KEY_W-1:0] top_r, top_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  mhpq_out_t               out_data_r, out_data_nxt;

  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_waddr, ram_raddr0, ram_raddr1;
  logic signed [KEY_W-1:0] ram_wdata;
  logic [KEY_W-1:0]        rd0_raw, rd1_raw;
  logic signed [KEY_W-1:0] rd0, rd1;

  logic signed [KEY_W-1:0] cmp_a, cmp_b;
  logic                    cmp_lt;

  logic [CH_W-1:0]         lc_w, rc_w, count_w;
  logic [IDX_W-1:0]        parent;
  logic                    lc_ok, rc_ok;

  mhpq_ram #(
    .DATA_W (KEY_W),
    .DEPTH  (CAPACITY)
  ) u_heap_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re     (ram_re),
    .raddr0 (ram_raddr0),
    .raddr1 (ram_raddr1),
    .rdata0 (rd0_raw),
    .rdata1 (rd1_raw)
  );

  assign rd0 = $signed(rd0_raw);
  assign rd1 = $signed(rd1_raw);

  assign cmp_lt  = cmp_a < cmp_b;
  assign lc_w    = CH_W'({pos_r, 1'b1});
  assign rc_w    = lc_w + CH_W'(1);
  assign count_w = CH_W'(count_r);
  assign lc_ok   = lc_w < count_w;
  assign rc_ok   = rc_w < count_w;
  assign parent  = (pos_r - IDX_W'(1)) >> 1;

  assign busy       = state_r != S_IDLE;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    best_nxt       = best_r;
    take_l_nxt     = take_l_r;
    status_nxt     = status_r;
    removed_nxt    = removed_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = cur_r;
    ram_raddr0     = '0;
    ram_raddr1     = '0;
    cmp_a          = cur_r;
    cmp_b          = rd0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt  = STATUS_OK;
          removed_nxt = '0;
          if (in_data.opcode == OP_INSERT) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              status_nxt = STATUS_FULL;
              state_nxt  = S_DONE;
            end else begin
              pos_nxt   = IDX_W'(count_r);
              cur_nxt   = in_data.key_value;
              count_nxt = count_r + CNT_W'(1);
              state_nxt = S_UP;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = STATUS_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              removed_nxt = top_r;
              count_nxt   = count_r - CNT_W'(1);
              ram_re      = 1'b1;
              ram_raddr0  = IDX_W'(count_r - CNT_W'(1));
              state_nxt   = S_DN_LAST;
            end
          end
        end
      end
      S_UP: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ram_re     = 1'b1;
          ram_raddr0 = parent;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = rd0;
          pos_nxt   = parent;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DN_LAST: begin
        cur_nxt   = rd0;
        pos_nxt   = '0;
        state_nxt = (count_r == '0) ? S_DONE : S_DN;
      end
      S_DN: begin
        if (!lc_ok) begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ram_re     = 1'b1;
          ram_raddr0 = IDX_W'(lc_w);
          ram_raddr1 = IDX_W'(rc_w);
          state_nxt  = S_DN_CMPL;
        end
      end
      S_DN_CMPL: begin
        cmp_a      = rd0;
        cmp_b      = cur_r;
        take_l_nxt = cmp_lt;
        best_nxt   = cmp_lt ? rd0 : cur_r;
        state_nxt  = S_DN_CMPR;
      end
      S_DN_CMPR: begin
        cmp_a  = rd1;
        cmp_b  = best_r;
        ram_we = 1'b1;
        priority if (rc_ok && cmp_lt) begin
          ram_wdata = rd1;
          pos_nxt   = IDX_W'(rc_w);
          state_nxt = S_DN;
        end else if (take_l_r) begin
          ram_wdata = best_r;
          pos_nxt   = IDX_W'(lc_w);
          state_nxt = S_DN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        out_strobe_nxt             = 1'b1;
        out_data_nxt.status        = status_r;
        out_data_nxt.removed_value = removed_r;
        out_data_nxt.top_value     = (count_r == '0) ? EMPTY_TOP : top_r;
        out_data_nxt.entry_count   = ENTRY_W'(count_r);
        out_data_nxt.heap_empty    = count_r == '0;
        state_nxt                  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    top_nxt = top_r;
    if (ram_we && ram_waddr == '0) begin
      top_nxt = ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    take_l_r   <= take_l_nxt;
    status_r   <= status_nxt;
    removed_r  <= removed_nxt;
    top_r      <= top_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("heap count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_data_r.status == STATUS_FULL |-> count_r == CNT_W'(CAPACITY))
    else $error("overflow reported on a heap that is not full");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> CNT_W'(ram_waddr) < count_r)
    else $error("heap write beyond the live entries");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> !busy ##1 !out_strobe_r)
    else $error("result strobe repeated or sequencer busy during result");
`endif

endmodule

@@ rtl/mhpq_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps

module mhpq_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 64
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [DATA_W-1:0]          wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr0,
  input  logic [$clog2(DEPTH)-1:0]   raddr1,
  output logic [DATA_W-1:0]          rdata0,
  output logic [DATA_W-1:0]          rdata1
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule
